@@ rtl/lwbe_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package lwbe_pkg;

  // Field widths
  localparam int X_WIDTH   = 16;
  localparam int Q_WIDTH   = 16;
  localparam int W_WIDTH   = 18;
  localparam int REM_WIDTH = Q_WIDTH + 1;

  // Square root pipeline: four stages of four digits each
  localparam int SQRT_STAGES     = 4;
  localparam int STEPS_PER_STAGE = 4;

  // Horner chain
  localparam int POLY_DEGREE = 8;
  // Integer bits above the binary point for the accumulator (|acc| < 32, plus margin)
  localparam int ACC_IBITS   = 8;

  // Output saturation limits, Q2.16
  localparam int W_MAX = 131071;
  localparam int W_MIN = -131072;

  // Series coefficients, round(c * 2^32)
  localparam logic signed [63:0] COEF_Q32 [0:POLY_DEGREE] = '{
    -64'sd4294967296,
     64'sd10014334647,
    -64'sd7783287703,
     64'sd8317767301,
    -64'sd10108425442,
     64'sd13172058681,
    -64'sd17932929853,
     64'sd25160020339,
    -64'sd36082158627
  };

  // Square root working set carried between stages
  typedef struct packed {
    logic [X_WIDTH-1:0]   xs;    // digits not yet consumed, MSB first
    logic [REM_WIDTH-1:0] rem;   // partial remainder
    logic [Q_WIDTH-1:0]   root;  // partial root
  } sqrt_pl_t;

  // Coefficient k in Q(frac), rounded half toward +inf from Q32
  function automatic logic signed [63:0] coef_fixed(input int k, input int frac);
    int                 s;
    logic signed [63:0] half;
    s    = 32 - frac;
    half = 64'sd1 <<< (s - 1);
    return (COEF_Q32[k] + half) >>> s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/lwbe_sqrt_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lwbe_sqrt_stage
  import lwbe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire sqrt_pl_t pl_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output sqrt_pl_t      pl_o
);

  logic     v_r;
  sqrt_pl_t pl_r;
  sqrt_pl_t pl_nxt;

  // Four restoring square-root digits
  always_comb begin
    logic [X_WIDTH-1:0]   xs;
    logic [REM_WIDTH-1:0] rem;
    logic [Q_WIDTH-1:0]   root;
    logic [REM_WIDTH+1:0] remw;
    logic [REM_WIDTH+1:0] trial;
    xs   = pl_i.xs;
    rem  = pl_i.rem;
    root = pl_i.root;
    for (int n = 0; n < STEPS_PER_STAGE; n++) begin
      remw  = {rem, xs[X_WIDTH-1 -: 2]};
      trial = {1'b0, root, 2'b01};
      if (remw >= trial) begin
        remw = remw - trial;
        root = {root[Q_WIDTH-2:0], 1'b1};
      end else begin
        root = {root[Q_WIDTH-2:0], 1'b0};
      end
      rem = remw[REM_WIDTH-1:0];
      xs  = {xs[X_WIDTH-3:0], 2'b00};
    end
    pl_nxt.xs   = xs;
    pl_nxt.rem  = rem;
    pl_nxt.root = root;
  end

  // Stage register; a bubble can be filled while downstream stalls
  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      pl_r <= pl_nxt;
    end
  end

  assign valid_o = v_r;
  assign pl_o    = pl_r;

endmodule

`default_nettype wire

@@ rtl/lwbe_horner_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lwbe_horner_stage
  import lwbe_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int K         = 7
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             valid_i,
  output logic                                  ready_o,
  input  wire logic signed [FRAC_BITS+ACC_IBITS-1:0] acc_i,
  input  wire logic [Q_WIDTH-1:0]               q_i,
  output logic                                  valid_o,
  input  wire logic                             ready_i,
  output logic signed [FRAC_BITS+ACC_IBITS-1:0] acc_o,
  output logic [Q_WIDTH-1:0]                    q_o
);

  localparam int AW = FRAC_BITS + ACC_IBITS;
  localparam int PW = AW + Q_WIDTH + 1;

  localparam logic signed [63:0]   CK64 = coef_fixed(K, FRAC_BITS);
  localparam logic signed [AW-1:0] CK   = CK64[AW-1:0];
  localparam logic signed [PW-1:0] RND  = PW'(1) <<< (Q_WIDTH - 1);

  logic                 v_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;
  logic [Q_WIDTH-1:0]   q_r;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_sh;

  // acc*q, rounded half up back to Q(FRAC_BITS), plus next coefficient
  assign prod    = PW'(acc_i) * PW'($signed({1'b0, q_i}));
  assign prod_sh = (prod + RND) >>> Q_WIDTH;
  assign acc_nxt = prod_sh[AW-1:0] + CK;

  assign ready_o = !v_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      acc_r <= acc_nxt;
      q_r   <= q_i;
    end
  end

  assign valid_o = v_r;
  assign acc_o   = acc_r;
  assign q_o     = q_r;

endmodule

`default_nettype wire

@@ rtl/lwbe_out_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module lwbe_out_stage
  import lwbe_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire logic signed [FRAC_BITS+ACC_IBITS-1:0] acc_i,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [W_WIDTH-1:0]                  out_w_value
);

  localparam int AW = FRAC_BITS + ACC_IBITS;
  localparam int WW = AW + 5;

  localparam logic signed [WW-1:0] WMAX_W = WW'(W_MAX);
  localparam logic signed [WW-1:0] WMIN_W = WW'(W_MIN);

  logic                      v_r;
  logic signed [W_WIDTH-1:0] w_r;
  logic signed [W_WIDTH-1:0] w_nxt;
  logic signed [WW-1:0]      accx;
  logic signed [WW-1:0]      wide;

  assign accx = {{(WW-AW){acc_i[AW-1]}}, acc_i};

  // Bring the accumulator to Q16
  generate
    if (FRAC_BITS > 16) begin : g_down
      localparam int SH = FRAC_BITS - 16;
      localparam logic signed [WW-1:0] RNDO = WW'(1) <<< (SH - 1);
      assign wide = (accx + RNDO) >>> SH;
    end else if (FRAC_BITS < 16) begin : g_up
      assign wide = accx <<< (16 - FRAC_BITS);
    end else begin : g_same
      assign wide = accx;
    end
  endgenerate

  // Saturate to the Q2.16 field
  always_comb begin
    if (wide > WMAX_W) begin
      w_nxt = WMAX_W[W_WIDTH-1:0];
    end else if (wide < WMIN_W) begin
      w_nxt = WMIN_W[W_WIDTH-1:0];
    end else begin
      w_nxt = wide[W_WIDTH-1:0];
    end
  end

  // Output register
  assign ready_o = !v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready_o) begin
      v_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      w_r <= w_nxt;
    end
  end

  assign out_valid   = v_r;
  assign out_w_value = w_r;

endmodule

`default_nettype wire

@@ rtl/lambert_w_near_branch_eval_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Lambert W near the branch point: for an unsigned Q0.16 argument x the core
// forms q = floor(sqrt(x)) in Q0.16, evaluates the degree-8 branch-point series
// in q by Horner's rule in signed Q(FRAC_BITS), and returns W as signed Q2.16,
// rounded half up and saturated. One item is taken per cycle while the output
// does not stall. There are four square-root stages of four digits each, eight
// multiply-add stages (one Horner step each, a 16-bit q times the accumulator),
// and one rounding and saturation stage that doubles as the output register.
// Each stage holds its own valid bit, so bubbles close up during an output stall.
module lambert_w_near_branch_eval_core
  import lwbe_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [X_WIDTH-1:0]  in_x_arg,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [W_WIDTH-1:0] out_w_value
);

  localparam int AW = FRAC_BITS + ACC_IBITS;

  localparam logic signed [63:0] C_TOP64 = coef_fixed(POLY_DEGREE, FRAC_BITS);

  sqrt_pl_t s_pl  [0:SQRT_STAGES];
  logic     s_v   [0:SQRT_STAGES];
  logic     s_rdy [0:SQRT_STAGES];

  logic signed [AW-1:0] h_acc [0:POLY_DEGREE];
  logic [Q_WIDTH-1:0]   h_q   [0:POLY_DEGREE];
  logic                 h_v   [0:POLY_DEGREE];
  logic                 h_rdy [0:POLY_DEGREE];

  // Input transfer enters the square-root pipe
  assign s_pl[0].xs   = in_x_arg;
  assign s_pl[0].rem  = '0;
  assign s_pl[0].root = '0;
  assign s_v[0]       = in_valid;
  assign in_ready     = s_rdy[0];

  generate
    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
      lwbe_sqrt_stage u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (s_v[i]),
        .ready_o (s_rdy[i]),
        .pl_i    (s_pl[i]),
        .valid_o (s_v[i+1]),
        .ready_i (s_rdy[i+1]),
        .pl_o    (s_pl[i+1])
      );
    end
  endgenerate

  // Horner chain starts from the top coefficient
  assign h_acc[0]             = C_TOP64[AW-1:0];
  assign h_q[0]               = s_pl[SQRT_STAGES].root;
  assign h_v[0]               = s_v[SQRT_STAGES];
  assign s_rdy[SQRT_STAGES]   = h_rdy[0];

  generate
    for (genvar j = 0; j < POLY_DEGREE; j++) begin : g_horner
      lwbe_horner_stage #(
        .FRAC_BITS (FRAC_BITS),
        .K         (POLY_DEGREE - 1 - j)
      ) u_horner (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid_i (h_v[j]),
        .ready_o (h_rdy[j]),
        .acc_i   (h_acc[j]),
        .q_i     (h_q[j]),
        .valid_o (h_v[j+1]),
        .ready_i (h_rdy[j+1]),
        .acc_o   (h_acc[j+1]),
        .q_o     (h_q[j+1])
      );
    end
  endgenerate

  lwbe_out_stage #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (h_v[POLY_DEGREE]),
    .ready_o     (h_rdy[POLY_DEGREE]),
    .acc_i       (h_acc[POLY_DEGREE]),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_w_value (out_w_value)
  );

endmodule

`default_nettype wire
